>>> hdl/timed_task_dispatcher_unit_macros.svh
// Assertion macros shared by the dispatcher RTL.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef TIMED_TASK_DISPATCHER_UNIT_MACROS_SVH
`define TIMED_TASK_DISPATCHER_UNIT_MACROS_SVH

// same-cycle implication
`define TDU_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("tdu check failed");

// next-cycle implication
`define TDU_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("tdu check failed");

`endif

>>> hdl/tdu_pkg.sv
// Shared types and constants of the timed task dispatcher.
// No dependencies; used by tdu_div and timed_task_dispatcher_unit.
package tdu_pkg;

    localparam int TASK_SLOTS_DEF = 16;
    localparam int TIME_W         = 32;
    localparam int DIVISOR_W      = 16;
    localparam int PADDR_W        = 3;

    localparam logic [7:0]  HPL_RESET = 8'd128;
    localparam logic [15:0] TP_RESET  = 16'd10;

    // register index, taken from paddr[2]
    localparam logic REG_HPL = 1'b0;
    localparam logic REG_TP  = 1'b1;

    // request kinds
    localparam logic REQ_ADD  = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    typedef struct packed {
        logic              req_type;
        logic [7:0]        task_tag;
        logic [TIME_W-1:0] due_time;
        logic [7:0]        task_priority;
        logic              is_recurring;
        logic [TIME_W-1:0] repeat_interval;
        logic [TIME_W-1:0] current_time;
    } t_req;

    typedef struct packed {
        logic              accepted;
        logic              dispatch_valid;
        logic [7:0]        dispatched_tag;
        logic              last_of_run;
        logic [TIME_W-1:0] next_due;
        logic              queue_empty;
    } t_rsp;

endpackage

>>> hdl/tdu_div.sv
// Radix-2 restoring divider: 32-bit elapsed time by 16-bit tick period.
// Depends on tdu_pkg for widths.
module tdu_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [tdu_pkg::TIME_W-1:0]    i_dividend,
    input  logic [tdu_pkg::DIVISOR_W-1:0] i_divisor,
    output logic                          o_done,
    output logic [tdu_pkg::TIME_W-1:0]    o_quotient
);
    import tdu_pkg::*;

    localparam int SW = $clog2(TIME_W);

    logic                 r_busy, n_busy;
    logic                 r_done, n_done;
    logic [SW-1:0]        r_cnt, n_cnt;
    logic [DIVISOR_W-1:0] r_rem, n_rem;
    logic [DIVISOR_W-1:0] r_dsr, n_dsr;
    logic [TIME_W-1:0]    r_quo, n_quo;
    logic [DIVISOR_W:0]   trial;

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_dsr  = r_dsr;
        n_quo  = r_quo;
        trial  = {r_rem, r_quo[TIME_W-1]};
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_rem  = '0;
            n_dsr  = i_divisor;
            n_quo  = i_dividend;
        end else if (r_busy) begin
            if (trial >= {1'b0, r_dsr}) begin
                n_rem = DIVISOR_W'(trial - {1'b0, r_dsr});
                n_quo = {r_quo[TIME_W-2:0], 1'b1};
            end else begin
                n_rem = trial[DIVISOR_W-1:0];
                n_quo = {r_quo[TIME_W-2:0], 1'b0};
            end
            n_cnt = r_cnt + SW'(1);
            if (r_cnt == SW'(TIME_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_cnt <= n_cnt;
        r_rem <= n_rem;
        r_dsr <= n_dsr;
        r_quo <= n_quo;
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

>>> hdl/timed_task_dispatcher_unit.sv
// Add item: the response is registered from S_ADD once the output register is free.
// Tick item: one read and evaluate per slot, with the serial divider for each due slot,
// then one select sweep of the slot memory per dispatched task, a re-store pass over
// the dispatched tasks, and a final sweep for the next due time.
// One item at a time; the slot memory's single read port sets every sweep.
// Reset clears control, slot occupancy and config; slot memories stay unwritten.
`include "timed_task_dispatcher_unit_macros.svh"
module timed_task_dispatcher_unit #(
    parameter int TASK_SLOTS = tdu_pkg::TASK_SLOTS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  tdu_pkg::t_req               i_in_data,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output tdu_pkg::t_rsp               o_out_data,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [tdu_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    import tdu_pkg::*;

    localparam int IW = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
    localparam int CW = $clog2(TASK_SLOTS + 1);
    localparam logic [IW-1:0] LAST_IDX = IW'(TASK_SLOTS - 1);

    typedef struct packed {
        logic [7:0]        tag;
        logic [TIME_W-1:0] due;
        logic [7:0]        prio;
        logic              rep;
        logic [TIME_W-1:0] ivl;
    } t_info;

    typedef struct packed {
        t_info             info;
        logic [TIME_W-1:0] score;
    } t_slot;

    typedef enum logic [13:0] {
        S_IDLE     = 14'b00000000000001,
        S_ADD      = 14'b00000000000010,
        S_SCAN_RD  = 14'b00000000000100,
        S_SCAN_EV  = 14'b00000000001000,
        S_DIV      = 14'b00000000010000,
        S_SEL      = 14'b00000000100000,
        S_SEL_END  = 14'b00000001000000,
        S_GRAB     = 14'b00000010000000,
        S_COPY     = 14'b00000100000000,
        S_REST_RD  = 14'b00001000000000,
        S_REST_WR  = 14'b00010000000000,
        S_NEXT     = 14'b00100000000000,
        S_NEXT_END = 14'b01000000000000,
        S_LAST     = 14'b10000000000000
    } t_state;

    function automatic logic [IW-1:0] first_free(input logic [TASK_SLOTS-1:0] used);
        logic [IW-1:0] idx;
        idx = '0;
        for (int i = TASK_SLOTS - 1; i >= 0; i--) begin
            if (!used[i]) idx = IW'(i);
        end
        return idx;
    endfunction

    // memories
    t_slot r_slot_mem [TASK_SLOTS];
    t_slot r_slot_q;
    t_info r_pend_mem [TASK_SLOTS];
    t_info r_pend_q;

    logic          slot_we;
    logic [IW-1:0] slot_wa, slot_ra;
    t_slot         slot_wd;
    logic          pend_we;
    t_info         pend_wd;

    t_state                  r_state, n_state;
    logic [7:0]              r_hpl, n_hpl;
    logic [15:0]             r_tp, n_tp;
    logic [TASK_SLOTS-1:0]   r_used, n_used;
    logic [TASK_SLOTS-1:0]   r_picked, n_picked;
    logic [CW-1:0]           r_count, n_count;
    logic [TIME_W-1:0]       r_now, n_now;
    logic [DIVISOR_W-1:0]    r_div, n_div;
    logic [IW-1:0]           r_idx, n_idx;
    t_info                   r_ent, n_ent;
    logic [IW-1:0]           r_best, n_best;
    logic [TIME_W-1:0]       r_best_score, n_best_score;
    logic                    r_have, n_have;
    logic                    r_chk_vld, n_chk_vld;
    logic [IW-1:0]           r_chk_idx, n_chk_idx;
    logic [CW-1:0]           r_n, n_n;
    logic [IW-1:0]           r_k, n_k;
    logic [7:0]              r_last_tag, n_last_tag;
    logic                    r_disp, n_disp;
    logic [TIME_W-1:0]       r_nd, n_nd;
    logic [TIME_W-1:0]       r_nd_key, n_nd_key;
    logic                    r_any, n_any;
    logic                    r_acc, n_acc;
    logic                    r_out_valid, n_out_valid;
    t_rsp                    r_out, n_out;

    logic                    out_free;
    logic                    full;
    logic [TIME_W-1:0]       elapsed;
    logic                    is_due;
    logic [9:0]              band;
    logic                    div_start, div_done;
    logic [TIME_W-1:0]       div_quo;
    logic [TASK_SLOTS-1:0]   best_mask;
    logic [TASK_SLOTS-1:0]   rest;
    logic [TIME_W-1:0]       cand_key;
    logic [IW-1:0]           free_idx;

    tdu_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (elapsed),
        .i_divisor  (r_div),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    assign out_free  = !r_out_valid || i_out_ready;
    assign full      = (r_count == CW'(TASK_SLOTS));
    assign elapsed   = r_now - r_slot_q.info.due;
    assign is_due    = r_used[r_idx] && !elapsed[TIME_W-1];
    assign div_start = (r_state == S_SCAN_EV) && is_due;
    assign band      = (r_ent.prio >= r_hpl) ? {r_ent.prio, 2'b00}
                                             : {1'b0, r_ent.prio, 1'b0};
    assign cand_key  = (r_slot_q.info.due - r_now) ^ {1'b1, {(TIME_W-1){1'b0}}};
    assign free_idx  = first_free(r_used);

    always_comb begin
        best_mask         = '0;
        best_mask[r_best] = 1'b1;
        rest              = r_picked & ~best_mask;
    end

    always_comb begin
        n_state      = r_state;
        n_hpl        = r_hpl;
        n_tp         = r_tp;
        n_used       = r_used;
        n_picked     = r_picked;
        n_count      = r_count;
        n_now        = r_now;
        n_div        = r_div;
        n_idx        = r_idx;
        n_ent        = r_ent;
        n_best       = r_best;
        n_best_score = r_best_score;
        n_have       = r_have;
        n_chk_vld    = 1'b0;
        n_chk_idx    = r_chk_idx;
        n_n          = r_n;
        n_k          = r_k;
        n_last_tag   = r_last_tag;
        n_disp       = r_disp;
        n_nd         = r_nd;
        n_nd_key     = r_nd_key;
        n_any        = r_any;
        n_acc        = r_acc;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_out        = r_out;
        slot_we      = 1'b0;
        slot_wa      = free_idx;
        slot_wd      = '0;
        slot_ra      = r_idx;
        pend_we      = 1'b0;
        pend_wd      = r_slot_q.info;

        if (psel && penable && pwrite) begin
            unique case (paddr[2])
                REG_HPL: n_hpl = pwdata[7:0];
                REG_TP:  n_tp  = pwdata[15:0];
                default: ;
            endcase
        end

        // running best score over picked slots
        if (r_chk_vld && (r_state == S_SEL || r_state == S_SEL_END)) begin
            if (r_picked[r_chk_idx] && (!r_have || r_slot_q.score > r_best_score)) begin
                n_have       = 1'b1;
                n_best       = r_chk_idx;
                n_best_score = r_slot_q.score;
            end
        end
        // running earliest due over occupied slots
        if (r_chk_vld && (r_state == S_NEXT || r_state == S_NEXT_END)) begin
            if (r_used[r_chk_idx] && (!r_any || cand_key < r_nd_key)) begin
                n_any    = 1'b1;
                n_nd_key = cand_key;
                n_nd     = r_slot_q.info.due;
            end
        end

        unique case (r_state) inside
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_in_data.req_type == REQ_ADD) begin
                        n_acc = !full;
                        if (!full) begin
                            slot_we        = 1'b1;
                            slot_wd.info   = {i_in_data.task_tag, i_in_data.due_time,
                                              i_in_data.task_priority,
                                              i_in_data.is_recurring,
                                              i_in_data.repeat_interval};
                            n_used[free_idx] = 1'b1;
                            n_count        = r_count + CW'(1);
                        end
                        n_state = S_ADD;
                    end else begin
                        n_now    = i_in_data.current_time;
                        n_div    = (r_tp == '0) ? DIVISOR_W'(1) : r_tp;
                        n_idx    = '0;
                        n_picked = '0;
                        n_n      = '0;
                        n_disp   = 1'b0;
                        n_state  = S_SCAN_RD;
                    end
                end
            end
            S_ADD: begin
                if (out_free) begin
                    n_out_valid        = 1'b1;
                    n_out              = '0;
                    n_out.accepted     = r_acc;
                    n_out.last_of_run  = 1'b1;
                    n_out.queue_empty  = (r_count == '0);
                    n_state            = S_IDLE;
                end
            end
            S_SCAN_RD: n_state = S_SCAN_EV;
            S_SCAN_EV, S_DIV: begin
                if (r_state == S_SCAN_EV) n_ent = r_slot_q.info;
                if (r_state == S_SCAN_EV && is_due) begin
                    n_picked[r_idx] = 1'b1;
                    n_state         = S_DIV;
                end else if (r_state == S_DIV && !div_done) begin
                    n_state = S_DIV;
                end else begin
                    if (r_state == S_DIV) begin
                        slot_we       = 1'b1;
                        slot_wa       = r_idx;
                        slot_wd.info  = r_ent;
                        slot_wd.score = {{(TIME_W-10){1'b0}}, band} + div_quo;
                    end
                    if (r_idx == LAST_IDX) begin
                        n_idx  = '0;
                        n_have = 1'b0;
                        n_any  = 1'b0;
                        n_state = (n_picked != '0) ? S_SEL : S_NEXT;
                    end else begin
                        n_idx   = r_idx + IW'(1);
                        n_state = S_SCAN_RD;
                    end
                end
            end
            S_SEL: begin
                n_chk_vld = 1'b1;
                n_chk_idx = r_idx;
                if (r_idx == LAST_IDX) begin
                    n_state = S_SEL_END;
                end else begin
                    n_idx = r_idx + IW'(1);
                end
            end
            S_SEL_END: n_state = S_GRAB;
            S_GRAB: begin
                slot_ra = r_best;
                n_state = S_COPY;
            end
            S_COPY: begin
                slot_ra = r_best;
                pend_we = 1'b1;
                if (rest != '0) begin
                    if (out_free) begin
                        n_out_valid          = 1'b1;
                        n_out                = '0;
                        n_out.dispatch_valid = 1'b1;
                        n_out.dispatched_tag = r_slot_q.info.tag;
                        n_picked             = rest;
                        n_used               = r_used & ~best_mask;
                        n_count              = r_count - CW'(1);
                        n_n                  = r_n + CW'(1);
                        n_idx                = '0;
                        n_have               = 1'b0;
                        n_state              = S_SEL;
                    end
                end else begin
                    n_picked   = rest;
                    n_used     = r_used & ~best_mask;
                    n_count    = r_count - CW'(1);
                    n_n        = r_n + CW'(1);
                    n_last_tag = r_slot_q.info.tag;
                    n_disp     = 1'b1;
                    n_k        = '0;
                    n_state    = S_REST_RD;
                end
            end
            S_REST_RD: n_state = S_REST_WR;
            S_REST_WR: begin
                if (r_pend_q.rep) begin
                    slot_we            = 1'b1;
                    slot_wd.info       = r_pend_q;
                    slot_wd.info.due   = r_pend_q.due + r_pend_q.ivl;
                    n_used[free_idx]   = 1'b1;
                    n_count            = r_count + CW'(1);
                end
                if (CW'(r_k) + CW'(1) == r_n) begin
                    n_idx   = '0;
                    n_any   = 1'b0;
                    n_state = S_NEXT;
                end else begin
                    n_k     = r_k + IW'(1);
                    n_state = S_REST_RD;
                end
            end
            S_NEXT: begin
                n_chk_vld = 1'b1;
                n_chk_idx = r_idx;
                if (r_idx == LAST_IDX) begin
                    n_state = S_NEXT_END;
                end else begin
                    n_idx = r_idx + IW'(1);
                end
            end
            S_NEXT_END: n_state = S_LAST;
            S_LAST: begin
                if (out_free) begin
                    n_out_valid          = 1'b1;
                    n_out                = '0;
                    n_out.dispatch_valid = r_disp;
                    n_out.dispatched_tag = r_disp ? r_last_tag : 8'd0;
                    n_out.last_of_run    = 1'b1;
                    n_out.next_due       = r_any ? r_nd
                                         : r_now + {{(TIME_W-DIVISOR_W){1'b0}}, r_div};
                    n_out.queue_empty    = !r_any;
                    n_state              = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (slot_we) r_slot_mem[slot_wa] <= slot_wd;
        r_slot_q <= r_slot_mem[slot_ra];
        if (pend_we) r_pend_mem[r_n[IW-1:0]] <= pend_wd;
        r_pend_q <= r_pend_mem[r_k];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_hpl       <= HPL_RESET;
            r_tp        <= TP_RESET;
            r_used      <= '0;
            r_picked    <= '0;
            r_count     <= '0;
            r_chk_vld   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_hpl       <= n_hpl;
            r_tp        <= n_tp;
            r_used      <= n_used;
            r_picked    <= n_picked;
            r_count     <= n_count;
            r_chk_vld   <= n_chk_vld;
            r_out_valid <= n_out_valid;
        end
        r_now        <= n_now;
        r_div        <= n_div;
        r_idx        <= n_idx;
        r_ent        <= n_ent;
        r_best       <= n_best;
        r_best_score <= n_best_score;
        r_have       <= n_have;
        r_chk_idx    <= n_chk_idx;
        r_n          <= n_n;
        r_k          <= n_k;
        r_last_tag   <= n_last_tag;
        r_disp       <= n_disp;
        r_nd         <= n_nd;
        r_nd_key     <= n_nd_key;
        r_any        <= n_any;
        r_acc        <= n_acc;
        r_out        <= n_out;
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign pready      = 1'b1;
    assign prdata      = (paddr[2] == REG_TP) ? {16'd0, r_tp} : {24'd0, r_hpl};

    `TDU_ASSERT_IMP(a_count_matches, i_clk, i_rst_n, 1'b1, r_count == CW'($countones(r_used)))
    `TDU_ASSERT_IMP(a_picked_in_used, i_clk, i_rst_n, 1'b1, (r_picked & ~r_used) == '0)
    `TDU_ASSERT_IMP(a_sel_has_pick, i_clk, i_rst_n, r_state == S_SEL || r_state == S_GRAB, r_picked != '0)
    `TDU_ASSERT_NEXT(a_accept_leaves_idle, i_clk, i_rst_n, i_in_valid && o_in_ready, r_state != S_IDLE)

endmodule

>>> verif/tdu_checker.sv
// Checker for the timed task dispatcher: watches request and response beats,
// predicts responses with its own slot table and compares them. Needs tdu_pkg.
module tdu_checker (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           i_in_ready,
    input  tdu_pkg::t_req  i_in_data,
    input  logic           i_out_valid,
    input  logic           i_out_ready,
    input  tdu_pkg::t_rsp  i_out_data,
    input  logic           i_cfg_we,
    input  logic           i_cfg_idx,
    input  logic [31:0]    i_cfg_data,
    output int             o_errors,
    output int             o_pending
);
    import tdu_pkg::*;

    localparam int NSLOT = TASK_SLOTS_DEF;

    logic [7:0]  hpl;
    logic [15:0] tperiod;
    logic        used   [NSLOT];
    logic [7:0]  tag_m  [NSLOT];
    logic [31:0] due_m  [NSLOT];
    logic [7:0]  prio_m [NSLOT];
    logic        rep_m  [NSLOT];
    logic [31:0] ivl_m  [NSLOT];
    int          fill;
    t_rsp        expected_rsp[$];

    function automatic bit store_slot(logic [7:0] tg, logic [31:0] du, logic [7:0] pr,
                                      logic rp, logic [31:0] iv);
        if (fill >= NSLOT) return 0;
        for (int i = 0; i < NSLOT; i++) begin
            if (!used[i]) begin
                used[i] = 1; tag_m[i] = tg; due_m[i] = du;
                prio_m[i] = pr; rep_m[i] = rp; ivl_m[i] = iv;
                fill++;
                return 1;
            end
        end
        return 0;
    endfunction

    task automatic predict_dispatch(input t_req rq);
        t_rsp        r;
        bit          picked [NSLOT];
        logic [31:0] score  [NSLOT];
        logic [7:0]  run_tag  [NSLOT];
        logic [31:0] run_due  [NSLOT];
        logic [7:0]  run_prio [NSLOT];
        logic        run_rep  [NSLOT];
        logic [31:0] run_ivl  [NSLOT];
        int          nrun;
        logic [31:0] el, dv, key, bestkey, nd;
        int          best;
        bit          any, ok;
        r = '0;
        nrun = 0;
        if (rq.req_type == REQ_ADD) begin
            ok = store_slot(rq.task_tag, rq.due_time, rq.task_priority,
                            rq.is_recurring, rq.repeat_interval);
            r.accepted = ok;
            r.last_of_run = 1;
            r.queue_empty = (fill == 0);
            expected_rsp = {expected_rsp, r};
            return;
        end
        dv = (tperiod == 0) ? 32'd1 : {16'd0, tperiod};
        for (int i = 0; i < NSLOT; i++) begin
            el = rq.current_time - due_m[i];
            picked[i] = used[i] && !el[31];
            score[i] = 0;
            if (picked[i])
                score[i] = ((prio_m[i] >= hpl) ? ({24'd0, prio_m[i]} << 2)
                            : ({24'd0, prio_m[i]} << 1)) + el / dv;
        end
        // dispatched entries are copied out before any re-store reuses their slots
        forever begin
            best = -1;
            for (int i = 0; i < NSLOT; i++)
                if (picked[i] && (best < 0 || score[i] > score[best])) best = i;
            if (best < 0) break;
            picked[best] = 0;
            used[best] = 0;
            fill--;
            run_tag[nrun] = tag_m[best];
            run_due[nrun] = due_m[best];
            run_prio[nrun] = prio_m[best];
            run_rep[nrun] = rep_m[best];
            run_ivl[nrun] = ivl_m[best];
            nrun++;
        end
        for (int k = 0; k < nrun; k++)
            if (run_rep[k])
                ok = store_slot(run_tag[k], run_due[k] + run_ivl[k],
                                run_prio[k], 1'b1, run_ivl[k]);
        any = 0; nd = 0; bestkey = 0;
        for (int i = 0; i < NSLOT; i++) begin
            if (used[i]) begin
                key = (due_m[i] - rq.current_time) ^ 32'h8000_0000;
                if (!any || key < bestkey) begin
                    any = 1; bestkey = key; nd = due_m[i];
                end
            end
        end
        if (!any) nd = rq.current_time + dv;
        if (nrun == 0) begin
            r.last_of_run = 1; r.next_due = nd; r.queue_empty = !any;
            expected_rsp = {expected_rsp, r};
            return;
        end
        for (int k = 0; k < nrun; k++) begin
            r = '0;
            r.dispatch_valid = 1;
            r.dispatched_tag = run_tag[k];
            if (k == nrun - 1) begin
                r.last_of_run = 1; r.next_due = nd; r.queue_empty = !any;
            end
            expected_rsp = {expected_rsp, r};
        end
    endtask

    always @(posedge i_clk) begin
        t_rsp want;
        if (!i_rst_n) begin
            hpl = HPL_RESET;
            tperiod = TP_RESET;
            fill = 0;
            for (int i = 0; i < NSLOT; i++) used[i] = 0;
            expected_rsp.delete();
            o_errors <= 0;
            o_pending <= 0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == REG_HPL) hpl = i_cfg_data[7:0];
                else tperiod = i_cfg_data[15:0];
            end
            if (i_in_valid && i_in_ready) predict_dispatch(i_in_data);
            if (i_out_valid && i_out_ready) begin
                if (expected_rsp.size() == 0) begin
                    if (o_errors < 10) $display("unexpected beat %h", i_out_data);
                    o_errors <= o_errors + 1;
                end else begin
                    want = expected_rsp.pop_front();
                    if (want !== i_out_data) begin
                        if (o_errors < 10) begin
                            $display("mismatch: exp acc%b dv%b tag%h last%b nd%h qe%b",
                                     want.accepted, want.dispatch_valid, want.dispatched_tag,
                                     want.last_of_run, want.next_due, want.queue_empty);
                            $display("          got acc%b dv%b tag%h last%b nd%h qe%b",
                                     i_out_data.accepted, i_out_data.dispatch_valid,
                                     i_out_data.dispatched_tag, i_out_data.last_of_run,
                                     i_out_data.next_due, i_out_data.queue_empty);
                        end
                        o_errors <= o_errors + 1;
                    end
                end
            end
            o_pending <= expected_rsp.size();
        end
    end
endmodule

>>> verif/testbench.sv
// Stimulus and verdict for the timed task dispatcher: register setup over APB,
// adds and ticks with random gaps and stalls. Needs tdu_pkg, tdu_checker, the RTL.
module testbench;
    import tdu_pkg::*;

    localparam int REQ_W = $bits(t_req);

    logic                 clk, rst_n;
    logic                 in_valid, in_ready, out_valid, out_ready;
    t_req                 in_data;
    t_rsp                 out_data;
    logic                 psel, penable, pwrite, pready;
    logic [PADDR_W-1:0]   paddr;
    logic [31:0]          pwdata, prdata;
    int                   errors, pending;
    int                   send_idle, recv_idle;
    logic [31:0]          now_t;

    timed_task_dispatcher_unit u_top (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .o_in_ready(in_ready), .i_in_data(in_data),
        .o_out_valid(out_valid), .i_out_ready(out_ready), .o_out_data(out_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    tdu_checker u_chk (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .i_in_ready(in_ready), .i_in_data(in_data),
        .i_out_valid(out_valid), .i_out_ready(out_ready), .i_out_data(out_data),
        .i_cfg_we(psel && penable && pwrite && pready), .i_cfg_idx(paddr[2]),
        .i_cfg_data(pwdata), .o_errors(errors), .o_pending(pending)
    );

    initial begin
        clk = 0;
        forever #10 clk = ~clk;
    end

    initial begin
        #400_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    // receiver stalls
    always @(posedge clk) begin
        out_ready <= ($urandom_range(99) >= recv_idle);
    end

    task automatic reg_write(input logic idx, input logic [31:0] val);
        psel <= 1; penable <= 0; pwrite <= 1;
        paddr <= {idx, 2'b00}; pwdata <= val;
        @(posedge clk);
        penable <= 1;
        @(posedge clk);
        psel <= 0; penable <= 0; pwrite <= 0;
        @(posedge clk);
    endtask

    // valid stays up between back-to-back beats; it drops only on an idle cycle
    task automatic send_beat(input t_req rq);
        while ($urandom_range(99) < send_idle) begin
            in_valid <= 0;
            @(posedge clk);
        end
        in_valid <= 1;
        in_data <= rq;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    task automatic put_task(input logic [7:0] tg, input logic [31:0] du,
                            input logic [7:0] pr, input logic rp, input logic [31:0] iv);
        t_req rq;
        rq = REQ_W'({$urandom, $urandom, $urandom, $urandom});
        rq.req_type = REQ_ADD;
        rq.task_tag = tg; rq.due_time = du; rq.task_priority = pr;
        rq.is_recurring = rp; rq.repeat_interval = iv;
        send_beat(rq);
    endtask

    task automatic tick_at(input logic [31:0] t);
        t_req rq;
        rq = REQ_W'({$urandom, $urandom, $urandom, $urandom});
        rq.req_type = REQ_TICK;
        rq.current_time = t;
        send_beat(rq);
    endtask

    // waits until the dispatcher is idle and every response has been checked
    task automatic drain;
        in_valid <= 0;
        @(posedge clk);
        while (!in_ready || pending != 0) @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    task automatic random_phase(input int count);
        int   r;
        logic [31:0] dl;
        for (int n = 0; n < count; n++) begin
            r = $urandom_range(99);
            if (r < 55) begin
                dl = (r < 5) ? $urandom : now_t + $urandom_range(300) - 50;
                put_task(8'($urandom), dl, 8'($urandom),
                         $urandom_range(2) == 0,
                         (r < 8) ? $urandom : $urandom_range(200));
            end else begin
                now_t = now_t + $urandom_range(120);
                tick_at(($urandom_range(30) == 0) ? $urandom : now_t);
            end
        end
    endtask

    initial begin
        rst_n = 0; in_valid = 0; in_data = '0;
        psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
        send_idle = 0; recv_idle = 0; now_t = 32'hFFFF_FF00;
        repeat (5) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: extremes, full table, wrap, empty tick
        put_task(8'h00, 32'h0000_0000, 8'h00, 1'b0, 32'h0);
        put_task(8'hFF, 32'hFFFF_FFFF, 8'hFF, 1'b1, 32'hFFFF_FFFF);
        put_task(8'hA5, 32'hFFFF_FF80, 8'd128, 1'b1, 32'd100);
        put_task(8'h5A, 32'h7FFF_FFFF, 8'd127, 1'b0, 32'h8000_0000);
        tick_at(32'h0000_0010);
        tick_at(32'h0000_0100);
        for (int i = 0; i < 14; i++) put_task(8'(i), 32'd500, 8'd7, i[0], 32'd20);
        tick_at(32'd600);
        tick_at(32'h8000_0000);
        tick_at(32'hFFFF_FFFF);
        drain;
        reg_write(REG_HPL, 32'd0);
        reg_write(REG_TP, 32'd0);
        put_task(8'h11, 32'd5, 8'd3, 1'b0, 32'd0);
        put_task(8'h22, 32'd5, 8'd3, 1'b0, 32'd0);
        tick_at(32'd9);
        tick_at(32'd9);
        drain;

        reg_write(REG_HPL, 32'd255);
        reg_write(REG_TP, 32'd65535);
        send_idle = 10; recv_idle = 83;
        random_phase(131);
        drain;
        reg_write(REG_HPL, $urandom_range(255));
        reg_write(REG_TP, $urandom_range(1, 40));
        send_idle = 83; recv_idle = 10;
        random_phase(131);
        drain;
        reg_write(REG_HPL, 32'd128);
        reg_write(REG_TP, 32'd1);
        send_idle = 0; recv_idle = 0;
        random_phase(131);
        drain;

        if (errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule

>>> timed_task_dispatcher_unit.f
+incdir+hdl
hdl/tdu_pkg.sv
hdl/tdu_div.sv
hdl/timed_task_dispatcher_unit.sv
verif/tdu_checker.sv
verif/testbench.sv
